@@ sv/b64d_pkg.sv @@
// Shared types and codes for the Base64 stream decoder.
`timescale 1ns / 1ps
package b64d_pkg;

  // Result kind as seen on the result port.
  typedef enum logic [1:0] {
    KindData  = 2'd0,
    KindEnd   = 2'd1,
    KindError = 2'd2
  } kind_e;

  // Class of one input character, decided by the front end.
  typedef enum logic [1:0] {
    ClsSym = 2'd0,
    ClsPad = 2'd1,
    ClsBad = 2'd2
  } cls_e;

  // Classified character as it travels from the front end to the back end.
  typedef struct packed {
    cls_e       cls;
    logic [5:0] value;
    logic       last;
  } item_t;

  // One result as held in the output queue.
  typedef struct packed {
    logic [7:0] data;
    kind_e      kind;
    logic       last;
  } result_t;

  // Position within a group of four characters.
  typedef enum logic [3:0] {
    Grp0 = 4'b0001,
    Grp1 = 4'b0010,
    Grp2 = 4'b0100,
    Grp3 = 4'b1000
  } grp_e;

endpackage

@@ sv/base64_decoder.sv @@
// Top level of the streaming Base64 decoder.
//
//   Channel   Direction  Handshake          Payload
//   input     in         push_i / full_o    char_i, last_i
//   result    out        pop_i / empty_o    byte_o, kind_o, last_o
//
// One character is taken per clock cycle when neither queue backs up.
// A result reaches the ports through the classification and output queues:
// the back end takes the classification queue head and writes the output queue.
// A stalled result side fills the output queue first, then the classification
// queue, and only then raises full_o.
// Reset clears both queues and the group state; no clearing pass is needed.
`timescale 1ns / 1ps
module base64_decoder #(
  parameter int unsigned QueueDepth = 2
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push_i,
  output logic       full_o,
  input  logic [7:0] char_i,
  input  logic       last_i,
  output logic       empty_o,
  input  logic       pop_i,
  output logic [7:0] byte_o,
  output logic [1:0] kind_o,
  output logic       last_o
);
  import b64d_pkg::*;

  localparam int unsigned ItemW = $bits(item_t);
  localparam int unsigned ResW  = $bits(result_t);

  item_t   front_item;
  item_t   back_item;
  logic    mid_empty;
  logic    mid_pop;
  logic    res_full;
  logic    res_push;
  result_t res_new;
  result_t res_head;

  b64d_front u_front (
    .char_i (char_i),
    .last_i (last_i),
    .item_o (front_item)
  );

  b64d_fifo #(
    .Depth (QueueDepth),
    .Width (ItemW)
  ) u_mid_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push_i),
    .data_i  (front_item),
    .full_o  (full_o),
    .pop_i   (mid_pop),
    .data_o  (back_item),
    .empty_o (mid_empty)
  );

  b64d_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_valid_i (!mid_empty),
    .item_i       (back_item),
    .item_pop_o   (mid_pop),
    .res_full_i   (res_full),
    .res_push_o   (res_push),
    .res_o        (res_new)
  );

  b64d_fifo #(
    .Depth (QueueDepth),
    .Width (ResW)
  ) u_res_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_push),
    .data_i  (res_new),
    .full_o  (res_full),
    .pop_i   (pop_i),
    .data_o  (res_head),
    .empty_o (empty_o)
  );

  assign byte_o = res_head.data;
  assign kind_o = res_head.kind;
  assign last_o = res_head.last;

endmodule

@@ sv/b64d_fifo.sv @@
// Small synchronous queue used between the decoder stages and at the output.
`timescale 1ns / 1ps
module b64d_fifo #(
  parameter int unsigned Depth = 2,
  parameter int unsigned Width = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [Width-1:0] data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [Width-1:0] data_o,
  output logic             empty_o
);
  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  logic [Width-1:0] mem_q [Depth];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  count_q, count_d;
  logic             push_ok, pop_ok;

  assign full_o  = (count_q == CntW'(Depth));
  assign empty_o = (count_q == '0);
  assign push_ok = push_i && !full_o;
  assign pop_ok  = pop_i && !empty_o;
  assign data_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    if (push_ok) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (pop_ok) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
    end
    count_d = count_q + CntW'(push_ok) - CntW'(pop_ok);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_ok) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

@@ sv/b64d_front.sv @@
// Front end: maps one raw character to its class and six-bit symbol value.
`timescale 1ns / 1ps
module b64d_front (
  input  logic              [7:0] char_i,
  input  logic                    last_i,
  output b64d_pkg::item_t         item_o
);
  import b64d_pkg::*;

  localparam logic [7:0] CharUpperA = 8'h41;
  localparam logic [7:0] CharUpperZ = 8'h5A;
  localparam logic [7:0] CharLowerA = 8'h61;
  localparam logic [7:0] CharLowerZ = 8'h7A;
  localparam logic [7:0] CharDigit0 = 8'h30;
  localparam logic [7:0] CharDigit9 = 8'h39;
  localparam logic [7:0] CharPlus   = 8'h2B;
  localparam logic [7:0] CharSlash  = 8'h2F;
  localparam logic [7:0] CharPad    = 8'h3D;
  localparam logic [7:0] LowerBase  = 8'd26;
  localparam logic [7:0] DigitBase  = 8'd52;
  localparam logic [5:0] PlusValue  = 6'd62;
  localparam logic [5:0] SlashValue = 6'd63;

  logic [7:0] sum;

  always_comb begin
    sum          = '0;
    item_o.cls   = ClsBad;
    item_o.value = '0;
    item_o.last  = last_i;
    if (char_i inside {[CharUpperA:CharUpperZ]}) begin
      item_o.cls   = ClsSym;
      sum          = char_i - CharUpperA;
      item_o.value = sum[5:0];
    end else if (char_i inside {[CharLowerA:CharLowerZ]}) begin
      item_o.cls   = ClsSym;
      sum          = char_i - CharLowerA + LowerBase;
      item_o.value = sum[5:0];
    end else if (char_i inside {[CharDigit0:CharDigit9]}) begin
      item_o.cls   = ClsSym;
      sum          = char_i - CharDigit0 + DigitBase;
      item_o.value = sum[5:0];
    end else if (char_i == CharPlus) begin
      item_o.cls   = ClsSym;
      item_o.value = PlusValue;
    end else if (char_i == CharSlash) begin
      item_o.cls   = ClsSym;
      item_o.value = SlashValue;
    end else if (char_i == CharPad) begin
      item_o.cls   = ClsPad;
    end
  end

endmodule

@@ sv/b64d_back.sv @@
// Back end: group state, bit packing and result generation for each character.
`timescale 1ns / 1ps
module b64d_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              item_valid_i,
  input  b64d_pkg::item_t   item_i,
  output logic              item_pop_o,
  input  logic              res_full_i,
  output logic              res_push_o,
  output b64d_pkg::result_t res_o
);
  import b64d_pkg::*;

  grp_e       grp_q, grp_d;
  logic [5:0] held_q, held_d;
  logic       pad_q, pad_d;
  logic       err_q, err_d;
  logic       take;
  logic       emit;

  assign take       = item_valid_i && !res_full_i;
  assign item_pop_o = take;
  assign res_push_o = take && emit;

  always_comb begin
    grp_d      = grp_q;
    held_d     = held_q;
    pad_d      = pad_q;
    err_d      = err_q;
    emit       = 1'b0;
    res_o.data = '0;
    res_o.kind = KindData;
    res_o.last = 1'b1;

    if (err_q) begin
      // Characters are swallowed until the end of the message.
    end else if (item_i.cls == ClsPad) begin
      pad_d = 1'b1;
      if (item_i.last) begin
        emit       = 1'b1;
        res_o.kind = KindEnd;
      end
    end else if (item_i.cls == ClsBad || pad_q) begin
      err_d      = 1'b1;
      emit       = 1'b1;
      res_o.kind = KindError;
    end else begin
      res_o.last = item_i.last;
      case (grp_q)
        Grp0: begin
          held_d = item_i.value;
          grp_d  = Grp1;
        end
        Grp1: begin
          res_o.data = {held_q, item_i.value[5:4]};
          held_d     = {2'b00, item_i.value[3:0]};
          grp_d      = Grp2;
          emit       = 1'b1;
        end
        Grp2: begin
          res_o.data = {held_q[3:0], item_i.value[5:2]};
          held_d     = {4'b0000, item_i.value[1:0]};
          grp_d      = Grp3;
          emit       = 1'b1;
        end
        Grp3: begin
          res_o.data = {held_q[1:0], item_i.value};
          held_d     = '0;
          grp_d      = Grp0;
          emit       = 1'b1;
        end
        default: begin
          grp_d = Grp0;
        end
      endcase
      // A last character that completes no byte still closes the message.
      if (!emit && item_i.last) begin
        emit       = 1'b1;
        res_o.kind = KindEnd;
        res_o.last = 1'b1;
      end
    end

    if (item_i.last) begin
      grp_d  = Grp0;
      held_d = '0;
      pad_d  = 1'b0;
      err_d  = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      grp_q  <= Grp0;
      held_q <= '0;
      pad_q  <= 1'b0;
      err_q  <= 1'b0;
    end else if (take) begin
      grp_q  <= grp_d;
      held_q <= held_d;
      pad_q  <= pad_d;
      err_q  <= err_d;
    end
  end

endmodule

@@ sv/b64d_checker.sv @@
// Port-level checks for the Base64 decoder, bound to the top level.
`timescale 1ns / 1ps
module b64d_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       empty_o,
  input logic       pop_i,
  input logic [7:0] byte_o,
  input logic [1:0] kind_o,
  input logic       last_o
);
  import b64d_pkg::*;

  // Only the three defined kinds ever reach the result port.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty_o |-> (kind_o == KindData || kind_o == KindEnd || kind_o == KindError))
    else $error("undefined result kind");

  // End and error results always close the message.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty_o && kind_o != KindData) |-> last_o)
    else $error("non-data result without last");

  // End and error results carry a zero byte.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty_o && kind_o != KindData) |-> (byte_o == 8'd0))
    else $error("non-data result with nonzero byte");

  // A result that is not taken stays on the ports unchanged.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty_o && !pop_i) |=>
      (!empty_o && $stable(byte_o) && $stable(kind_o) && $stable(last_o)))
    else $error("waiting result changed before its transfer");

endmodule

bind base64_decoder b64d_checker u_b64d_checker (
  .clk_i   (clk_i),
  .rst_ni  (rst_ni),
  .empty_o (empty_o),
  .pop_i   (pop_i),
  .byte_o  (byte_o),
  .kind_o  (kind_o),
  .last_o  (last_o)
);
